/* hdl/ipv4frt_pkg.sv */
// Package for the IPv4 fragment reassembly tracker.
// Holds status codes, sequencer states, entry types and default sizes.
// No dependencies.
package ipv4frt_pkg;

    localparam int unsigned DefFlows        = 16;
    localparam int unsigned DefFragsPerFlow = 8;

    localparam logic [16:0] HdrBytes = 17'd34;

    typedef enum logic [2:0] {
        ST_IGNORED    = 3'd0,
        ST_OPENED     = 3'd1,
        ST_ADDED      = 3'd2,
        ST_DONE       = 3'd3,
        ST_FLOWS_FULL = 3'd4,
        ST_DUPLICATE  = 3'd5,
        ST_FRAGS_FULL = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_OPEN,
        S_SCAN,
        S_SHIFT,
        S_PLACE,
        S_WALK,
        S_FINISH
    } seq_state_t;

    typedef struct packed {
        logic [15:0] ident;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
    } flow_key_t;

    typedef struct packed {
        logic        mf;
        logic [12:0] off;
        logic [15:0] len;
    } frag_entry_t;

endpackage

/* hdl/ipv4frt_in_if.sv */
// Request channel carrying one IPv4 fragment descriptor.
// No dependencies.
interface ipv4frt_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] ident;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic        more_frags;
    logic [12:0] frag_offset;
    logic [15:0] frame_len;

    modport source (output valid, ident, src_addr, dst_addr, more_frags, frag_offset,
                    frame_len, input ready);
    modport sink   (input valid, ident, src_addr, dst_addr, more_frags, frag_offset,
                    frame_len, output ready);
endinterface

/* hdl/ipv4frt_res_if.sv */
// Result channel carrying the status of one fragment.
// No dependencies.
interface ipv4frt_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [3:0]  flow_slot;
    logic [16:0] total_len;

    modport source (output valid, status, flow_slot, total_len, input ready);
    modport sink   (input valid, status, flow_slot, total_len, output ready);
endinterface

/* hdl/ipv4_fragment_reassembly_tracker.sv */
// Top level of the IPv4 fragment reassembly tracker.
// Depends on ipv4frt_pkg, ipv4frt_in_if, ipv4frt_res_if and ipv4frt_ram.
//
//  channel   dir  modport  payload
//  frag_in   in   sink     ident, src_addr, dst_addr, more_frags, frag_offset, frame_len
//  result    out  source   status, flow_slot, total_len
//
// One request at a time. A fragment goes through the key search over the key RAM;
// a new flow is then opened, while a known flow gets the offset scan, the shift where
// needed, the place step and the contiguity walk over its stored fragments, all
// reading the one-read-a-cycle RAM ports. Unfragmented packets go straight to the result.
// Reset clears the flow valid bits and the sequencer; the RAMs need no clearing.
// A waiting result stalls only the final step; once it is loaded, the next request is taken.
module ipv4_fragment_reassembly_tracker
    import ipv4frt_pkg::*;
#(
    parameter int unsigned FLOWS          = DefFlows,
    parameter int unsigned FRAGS_PER_FLOW = DefFragsPerFlow
) (
    input  logic          clk,
    input  logic          rst_n,
    ipv4frt_in_if.sink    frag_in,
    ipv4frt_res_if.source result
);

    localparam int unsigned SW = (FLOWS > 1) ? $clog2(FLOWS) : 1;
    localparam int unsigned IW = $clog2(FRAGS_PER_FLOW);
    localparam int unsigned CW = $clog2(FRAGS_PER_FLOW + 1);
    localparam int unsigned AW = (FLOWS * FRAGS_PER_FLOW > 1) ?
                                 $clog2(FLOWS * FRAGS_PER_FLOW) : 1;
    localparam int unsigned KW = $bits(flow_key_t) + CW;

    localparam logic [SW-1:0] LastSlot = SW'(FLOWS - 1);
    localparam logic [CW-1:0] FragMax  = CW'(FRAGS_PER_FLOW);

    function automatic logic [AW-1:0] frag_addr(input logic [SW-1:0] s,
                                                input logic [IW-1:0] i);
        return AW'(s) * AW'(FRAGS_PER_FLOW) + AW'(i);
    endfunction

    seq_state_t  state_reg, state_next;
    flow_key_t   key_reg, key_next;
    frag_entry_t nf_reg, nf_next;
    frag_entry_t prev_reg, prev_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [SW-1:0] free_reg, free_next;
    logic          free_ok_reg, free_ok_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic          dup_reg, dup_next;
    logic          ok_reg, ok_next;
    logic [16:0]   sum_reg, sum_next;
    logic [SW-1:0] sptr_reg, sptr_next;
    logic [SW-1:0] stag_reg, stag_next;
    logic [CW-1:0] fptr_reg, fptr_next;
    logic [CW-1:0] ftag_reg, ftag_next;
    logic          iss_reg, iss_next;
    logic          tag_vld_reg, tag_vld_next;
    logic [FLOWS-1:0] valid_reg, valid_next;
    status_t       st_reg, st_next;
    logic [16:0]   tot_reg, tot_next;

    logic          res_valid_reg, res_valid_next;
    status_t       res_status_reg, res_status_next;
    logic [3:0]    res_slot_reg, res_slot_next;
    logic [16:0]   res_total_reg, res_total_next;

    // RAM ports
    logic          key_we;
    logic [SW-1:0] key_waddr, key_raddr;
    logic [KW-1:0] key_wdata, key_rdata;
    logic          frag_we;
    logic [AW-1:0] frag_waddr, frag_raddr;
    frag_entry_t   frag_wdata, frag_rdata;

    flow_key_t     rd_key;
    logic [CW-1:0] rd_cnt;
    logic          hit;
    logic          free_now;
    logic [SW-1:0] free_sel;
    logic [12:0]   diff;
    logic [16:0]   gap;
    logic          walk_ok;
    logic [SW+3:0] slot_ext;

    assign rd_key = key_rdata[KW-1:CW];
    assign rd_cnt = key_rdata[CW-1:0];

    ipv4frt_ram #(.WIDTH(KW), .DEPTH(FLOWS)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    ipv4frt_ram #(.WIDTH($bits(frag_entry_t)), .DEPTH(FLOWS * FRAGS_PER_FLOW)) u_frag_ram (
        .clk   (clk),
        .we    (frag_we),
        .waddr (frag_waddr),
        .wdata (frag_wdata),
        .raddr (frag_raddr),
        .rdata (frag_rdata)
    );

    assign frag_in.ready    = (state_reg == S_IDLE);
    assign result.valid     = res_valid_reg;
    assign result.status    = res_status_reg;
    assign result.flow_slot = res_slot_reg;
    assign result.total_len = res_total_reg;

    // hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            res_valid_reg <= 1'b0;
            iss_reg       <= 1'b0;
            tag_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            res_valid_reg <= res_valid_next;
            iss_reg       <= iss_next;
            tag_vld_reg   <= tag_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        nf_reg         <= nf_next;
        prev_reg       <= prev_next;
        slot_reg       <= slot_next;
        free_reg       <= free_next;
        free_ok_reg    <= free_ok_next;
        n_reg          <= n_next;
        pos_reg        <= pos_next;
        dup_reg        <= dup_next;
        ok_reg         <= ok_next;
        sum_reg        <= sum_next;
        sptr_reg       <= sptr_next;
        stag_reg       <= stag_next;
        fptr_reg       <= fptr_next;
        ftag_reg       <= ftag_next;
        st_reg         <= st_next;
        tot_reg        <= tot_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_total_reg  <= res_total_next;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        key_next        = key_reg;
        nf_next         = nf_reg;
        prev_next       = prev_reg;
        slot_next       = slot_reg;
        free_next       = free_reg;
        free_ok_next    = free_ok_reg;
        n_next          = n_reg;
        pos_next        = pos_reg;
        dup_next        = dup_reg;
        ok_next         = ok_reg;
        sum_next        = sum_reg;
        sptr_next       = sptr_reg;
        stag_next       = sptr_reg;
        fptr_next       = fptr_reg;
        ftag_next       = fptr_reg;
        iss_next        = iss_reg;
        tag_vld_next    = 1'b0;
        valid_next      = valid_reg;
        st_next         = st_reg;
        tot_next        = tot_reg;
        res_valid_next  = res_valid_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_total_next  = res_total_reg;

        key_we     = 1'b0;
        key_waddr  = slot_reg;
        key_wdata  = {key_reg, CW'(n_reg + CW'(1))};
        key_raddr  = sptr_reg;
        frag_we    = 1'b0;
        frag_waddr = frag_addr(slot_reg, pos_reg[IW-1:0]);
        frag_wdata = nf_reg;
        frag_raddr = frag_addr(slot_reg, fptr_reg[IW-1:0]);

        hit      = valid_reg[stag_reg] && (rd_key == key_reg);
        free_now = !free_ok_reg && !valid_reg[stag_reg];
        free_sel = free_now ? stag_reg : free_reg;
        diff     = frag_rdata.off - prev_reg.off;
        gap      = {1'b0, diff, 3'b000} + HdrBytes;
        walk_ok  = ok_reg && prev_reg.mf && (gap == {1'b0, prev_reg.len});
        slot_ext = {4'b0000, slot_reg};

        // drain the result register
        if (res_valid_reg && result.ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (frag_in.valid)
                begin
                    key_next     = '{frag_in.ident, frag_in.src_addr, frag_in.dst_addr};
                    nf_next      = '{frag_in.more_frags, frag_in.frag_offset,
                                     frag_in.frame_len};
                    sptr_next    = '0;
                    iss_next     = 1'b1;
                    free_ok_next = 1'b0;
                    slot_next    = '0;
                    tot_next     = '0;
                    if (!frag_in.more_frags && frag_in.frag_offset == 13'd0)
                    begin
                        st_next    = ST_IGNORED;
                        iss_next   = 1'b0;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SEARCH;
                    end
                end
            end

            S_SEARCH:
            begin
                // issue key reads
                tag_vld_next = iss_reg;
                if (iss_reg)
                begin
                    if (sptr_reg == LastSlot)
                    begin
                        iss_next = 1'b0;
                    end
                    else
                    begin
                        sptr_next = sptr_reg + SW'(1);
                    end
                end
                // compare returned key
                if (tag_vld_reg)
                begin
                    if (free_now)
                    begin
                        free_ok_next = 1'b1;
                        free_next    = stag_reg;
                    end
                    if (hit)
                    begin
                        slot_next    = stag_reg;
                        n_next       = rd_cnt;
                        pos_next     = '0;
                        dup_next     = 1'b0;
                        fptr_next    = '0;
                        iss_next     = 1'b1;
                        tag_vld_next = 1'b0;
                        state_next   = S_SCAN;
                    end
                    else if (stag_reg == LastSlot)
                    begin
                        iss_next     = 1'b0;
                        tag_vld_next = 1'b0;
                        if (free_ok_reg || free_now)
                        begin
                            slot_next  = free_sel;
                            state_next = S_OPEN;
                        end
                        else
                        begin
                            st_next    = ST_FLOWS_FULL;
                            slot_next  = '0;
                            state_next = S_FINISH;
                        end
                    end
                end
            end

            S_OPEN:
            begin
                // open the flow with its first fragment
                key_we     = 1'b1;
                key_wdata  = {key_reg, CW'(1)};
                frag_we    = 1'b1;
                frag_waddr = frag_addr(slot_reg, IW'(0));
                valid_next[slot_reg] = 1'b1;
                st_next    = ST_OPENED;
                state_next = S_FINISH;
            end

            S_SCAN:
            begin
                // issue fragment reads
                tag_vld_next = iss_reg;
                if (iss_reg)
                begin
                    if (fptr_reg == n_reg - CW'(1))
                    begin
                        iss_next = 1'b0;
                    end
                    else
                    begin
                        fptr_next = fptr_reg + CW'(1);
                    end
                end
                // check offset order and duplicates
                if (tag_vld_reg)
                begin
                    if (frag_rdata.off == nf_reg.off)
                    begin
                        dup_next = 1'b1;
                    end
                    if (frag_rdata.off < nf_reg.off)
                    begin
                        pos_next = pos_reg + CW'(1);
                    end
                    if (ftag_reg == n_reg - CW'(1))
                    begin
                        iss_next     = 1'b0;
                        tag_vld_next = 1'b0;
                        if (dup_next)
                        begin
                            st_next    = ST_DUPLICATE;
                            state_next = S_FINISH;
                        end
                        else if (n_reg >= FragMax)
                        begin
                            st_next    = ST_FRAGS_FULL;
                            state_next = S_FINISH;
                        end
                        else if (pos_next == n_reg)
                        begin
                            state_next = S_PLACE;
                        end
                        else
                        begin
                            fptr_next  = n_reg - CW'(1);
                            iss_next   = 1'b1;
                            state_next = S_SHIFT;
                        end
                    end
                end
            end

            S_SHIFT:
            begin
                // read downward, write one place up
                tag_vld_next = iss_reg;
                if (iss_reg)
                begin
                    if (fptr_reg == pos_reg)
                    begin
                        iss_next = 1'b0;
                    end
                    else
                    begin
                        fptr_next = fptr_reg - CW'(1);
                    end
                end
                if (tag_vld_reg)
                begin
                    frag_we    = 1'b1;
                    frag_waddr = frag_addr(slot_reg, IW'(ftag_reg + CW'(1)));
                    frag_wdata = frag_rdata;
                    if (ftag_reg == pos_reg)
                    begin
                        iss_next     = 1'b0;
                        tag_vld_next = 1'b0;
                        state_next   = S_PLACE;
                    end
                end
            end

            S_PLACE:
            begin
                // insert the fragment and bump the count
                frag_we    = 1'b1;
                key_we     = 1'b1;
                n_next     = n_reg + CW'(1);
                fptr_next  = '0;
                iss_next   = 1'b1;
                state_next = S_WALK;
            end

            S_WALK:
            begin
                tag_vld_next = iss_reg;
                if (iss_reg)
                begin
                    if (fptr_reg == n_reg - CW'(1))
                    begin
                        iss_next = 1'b0;
                    end
                    else
                    begin
                        fptr_next = fptr_reg + CW'(1);
                    end
                end
                // check contiguity and accumulate length
                if (tag_vld_reg)
                begin
                    prev_next = frag_rdata;
                    if (ftag_reg == '0)
                    begin
                        ok_next  = frag_rdata.mf && (frag_rdata.off == 13'd0);
                        sum_next = {1'b0, frag_rdata.len};
                    end
                    else
                    begin
                        ok_next  = walk_ok;
                        sum_next = sum_reg + {1'b0, frag_rdata.len} - HdrBytes;
                    end
                    if (ftag_reg == n_reg - CW'(1))
                    begin
                        iss_next     = 1'b0;
                        tag_vld_next = 1'b0;
                        state_next   = S_FINISH;
                        if (ok_next && !frag_rdata.mf)
                        begin
                            valid_next[slot_reg] = 1'b0;
                            st_next  = ST_DONE;
                            tot_next = sum_next;
                        end
                        else
                        begin
                            st_next = ST_ADDED;
                        end
                    end
                end
            end

            S_FINISH:
            begin
                // load the result once the register is free
                if (!res_valid_reg || result.ready)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = st_reg;
                    res_slot_next   = slot_ext[3:0];
                    res_total_next  = tot_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* hdl/ipv4frt_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ipv4frt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
